@@ src/hvn_pkg.sv @@
// Shared types and constants for the half vector normalizer.
`default_nettype none
package hvn_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int COMP_W        = 16;
    localparam int SUM_W         = 17;
    localparam int MSQ_W         = 34;
    localparam int LEN_W         = 36;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;

    typedef struct packed {
        logic signed [COMP_W-1:0] light_x;
        logic signed [COMP_W-1:0] light_y;
        logic signed [COMP_W-1:0] light_z;
        logic signed [COMP_W-1:0] view_x;
        logic signed [COMP_W-1:0] view_y;
        logic signed [COMP_W-1:0] view_z;
    } vec_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     nonzero;
    } vec_out_t;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MSQ_W-1:0] msq;
        logic [LEN_W-1:0]      len2;
    } work_t;

endpackage
`default_nettype wire

@@ src/hvn_front.sv @@
// Front end: component sums, magnitudes, squares and squared length.
`default_nettype none
module hvn_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire hvn_pkg::vec_in_t vec,
    output logic                wr_en,
    output hvn_pkg::work_t      wr_data,
    input  wire logic           q_full
);
    import hvn_pkg::*;

    logic                   v1_reg, v2_reg;
    logic                   adv;
    logic [2:0]             neg1_reg, neg2_reg;
    logic [2:0][SUM_W-1:0]  mag1_reg;
    logic [2:0][MSQ_W-1:0]  msq2_reg;
    logic [2:0][SUM_W-1:0]  mag_next;
    logic [2:0]             neg_next;
    logic signed [SUM_W-1:0] s [0:2];

    assign adv   = !(v2_reg && q_full);
    assign full  = !adv;
    assign wr_en = v2_reg && !q_full;

    always_comb
    begin
        s[0] = SUM_W'(vec.light_x) + SUM_W'(vec.view_x);
        s[1] = SUM_W'(vec.light_y) + SUM_W'(vec.view_y);
        s[2] = SUM_W'(vec.light_z) + SUM_W'(vec.view_z);
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = s[i][SUM_W-1];
            mag_next[i] = s[i][SUM_W-1] ? SUM_W'(-s[i]) : SUM_W'(s[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg1_reg <= neg_next;
            mag1_reg <= mag_next;
            neg2_reg <= neg1_reg;
            for (int i = 0; i < 3; i++)
                msq2_reg[i] <= MSQ_W'(mag1_reg[i]) * MSQ_W'(mag1_reg[i]);
        end
    end

    always_comb
    begin
        wr_data.neg  = neg2_reg;
        wr_data.msq  = msq2_reg;
        wr_data.len2 = LEN_W'(msq2_reg[0]) + LEN_W'(msq2_reg[1]) + LEN_W'(msq2_reg[2]);
    end

endmodule
`default_nettype wire

@@ src/hvn_queue.sv @@
// Short FIFO between front and back.
`default_nettype none
module hvn_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire hvn_pkg::work_t wr_data,
    output logic                q_full,
    input  wire logic           rd_en,
    output hvn_pkg::work_t      rd_data,
    output logic                q_empty
);
    import hvn_pkg::*;

    work_t             mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign q_full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!q_full || rd_en))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

@@ src/hvn_back.sv @@
// Back end: one quotient bit per stage, rounded scaling of each component.
`default_nettype none
module hvn_back #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire hvn_pkg::work_t rd_data,
    output logic                rd_en,
    output logic                empty,
    input  wire logic           pop,
    output hvn_pkg::vec_out_t   res
);
    import hvn_pkg::*;

    localparam int NS = FRAC_BITS + 1;
    localparam int W  = 2*FRAC_BITS + 42;
    localparam int RW = 2*FRAC_BITS + 36;

    // Per lane: P = t^2*L, Q = t*L with t = 2c-1; bit accepted when the
    // new P stays at or below R = 4*m^2*2^(2F).
    logic                 vld_reg [0:NS];
    logic [2:0]           neg_reg [0:NS];
    logic                 nz_reg  [0:NS];
    logic [W-1:0]         l_reg   [0:NS];
    logic [RW-1:0]        r_reg   [0:NS][0:2];
    logic signed [W-1:0]  p_reg   [0:NS][0:2];
    logic signed [W-1:0]  qv_reg  [0:NS][0:2];
    logic [FRAC_BITS:0]   c_reg   [0:NS][0:2];

    logic     out_vld_reg;
    vec_out_t out_reg;
    logic     adv;
    logic signed [W-1:0] lsx;

    assign adv   = !out_vld_reg || pop;
    assign rd_en = adv && !q_empty;
    assign empty = !out_vld_reg;
    assign res   = out_reg;
    assign lsx   = $signed(W'(rd_data.len2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0] <= rd_data.neg;
            nz_reg[0]  <= (rd_data.len2 != '0);
            l_reg[0]   <= W'(rd_data.len2);
            for (int i = 0; i < 3; i++)
            begin
                r_reg[0][i]  <= RW'(rd_data.msq[i]) << (2*FRAC_BITS + 2);
                p_reg[0][i]  <= lsx;
                qv_reg[0][i] <= -lsx;
                c_reg[0][i]  <= '0;
            end
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int B = FRAC_BITS - s;
        logic signed [W-1:0] lw;
        logic signed [W-1:0] pc [0:2];
        logic signed [W-1:0] qc [0:2];
        logic [2:0]          take;

        assign lw = $signed(l_reg[s]);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                pc[i]   = p_reg[s][i] + (qv_reg[s][i] <<< (B + 2)) + (lw <<< (2*B + 2));
                qc[i]   = qv_reg[s][i] + (lw <<< (B + 1));
                take[i] = (pc[i] <= $signed(W'(r_reg[s][i])));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (adv)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                neg_reg[s+1] <= neg_reg[s];
                nz_reg[s+1]  <= nz_reg[s];
                l_reg[s+1]   <= l_reg[s];
                for (int i = 0; i < 3; i++)
                begin
                    r_reg[s+1][i] <= r_reg[s][i];
                    if (take[i])
                    begin
                        p_reg[s+1][i]  <= pc[i];
                        qv_reg[s+1][i] <= qc[i];
                        c_reg[s+1][i]  <= c_reg[s][i] | ((FRAC_BITS+1)'(1) << B);
                    end
                    else
                    begin
                        p_reg[s+1][i]  <= p_reg[s][i];
                        qv_reg[s+1][i] <= qv_reg[s][i];
                        c_reg[s+1][i]  <= c_reg[s][i];
                    end
                end
            end
        end
    end

    logic signed [W-1:0] qw   [0:2];
    logic [COMP_W-1:0]   comp [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qw[i]   = $signed(W'(c_reg[NS][i]));
            comp[i] = nz_reg[NS] ? (neg_reg[NS][i] ? COMP_W'(-qw[i]) : COMP_W'(qw[i]))
                                 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vld_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.out_x   <= comp[0];
            out_reg.out_y   <= comp[1];
            out_reg.out_z   <= comp[2];
            out_reg.nonzero <= nz_reg[NS];
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !pop) |=> (out_vld_reg && $stable(out_reg)))
        else $error("result changed while stalled");
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.nonzero) |->
        (out_reg.out_x == '0 && out_reg.out_y == '0 && out_reg.out_z == '0))
        else $error("zero-length result not cleared");
    a_read_adv: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> adv)
        else $error("queue read without pipeline advance");

endmodule
`default_nettype wire

@@ src/half_vector_normalizer_top.sv @@
// Path from push to result: the front registers, the queue, the back input register,
// (FRAC_BITS+1) bit stages and 1 output register. Throughput: one item per cycle
// unless stalled; the back pipeline resolves one quotient bit per stage.
// A 4-entry queue between front and back absorbs stalls on either side.
// Reset (rst_n low, asynchronous) empties all pipelines, the queue and the output register.
`default_nettype none
module half_vector_normalizer_top #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire hvn_pkg::vec_in_t  vec,
    output logic                   empty,
    input  wire logic              pop,
    output hvn_pkg::vec_out_t      res
);
    import hvn_pkg::*;

    work_t wr_data, rd_data;
    logic  wr_en, rd_en, q_full, q_empty;

    hvn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .vec     (vec),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .q_full  (q_full)
    );

    hvn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_data (rd_data),
        .q_empty (q_empty)
    );

    hvn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

endmodule
`default_nettype wire

@@ bench/hvn_checker.sv @@
// Scoreboard for the half vector normalizer: predicts each transfer's result and compares.
`timescale 1ns / 100ps
module hvn_checker #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  hvn_pkg::vec_in_t  vec,
    input  logic              empty,
    input  logic              pop,
    input  hvn_pkg::vec_out_t res,
    output int                mismatches,
    output int                pending,
    output int                results_seen
);
    import hvn_pkg::*;

    vec_out_t expected_q[$];

    // Largest q in [0, 2^F] with (2q-1)^2 * len2 <= 4 * mag^2 * 2^(2F).
    function automatic longint unsigned unit_mag(longint unsigned mag,
                                                 longint unsigned len2);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
        lo  = 0;
        hi  = 64'd1 << FRAC_BITS;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t   = 2 * mid - 1;
            lhs = 128'(t) * 128'(t) * 128'(len2);
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic vec_out_t half_vector(vec_in_t v);
        vec_out_t        r;
        longint          s[3];
        longint unsigned m[3];
        longint unsigned len2;
        longint unsigned q;
        logic [15:0]     c;
        s[0] = longint'(v.light_x) + longint'(v.view_x);
        s[1] = longint'(v.light_y) + longint'(v.view_y);
        s[2] = longint'(v.light_z) + longint'(v.view_z);
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (s[i] < 0) ? -s[i] : s[i];
            len2 += m[i] * m[i];
        end
        r = '0;
        if (len2 == 0)
            return r;
        for (int i = 0; i < 3; i++)
        begin
            if (len2 == (64'd1 << (2 * FRAC_BITS)))
                q = m[i];
            else
                q = unit_mag(m[i], len2);
            c = (s[i] < 0) ? 16'(-q) : 16'(q);
            if (i == 0) r.out_x = c;
            else if (i == 1) r.out_y = c;
            else r.out_z = c;
        end
        r.nonzero = 1'b1;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec_out_t e;
        if (!rst_n)
        begin
            mismatches   <= 0;
            results_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(half_vector(vec));
            if (pop && !empty)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t unexpected result %h", $time, res);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.out_x !== res.out_x || e.out_y !== res.out_y ||
                        e.out_z !== res.out_z || e.nonzero !== res.nonzero)
                    begin
                        if (mismatches < 10)
                            $display("%0t mismatch: expected x=%0d y=%0d z=%0d nz=%b, got x=%0d y=%0d z=%0d nz=%b",
                                     $time, e.out_x, e.out_y, e.out_z, e.nonzero,
                                     res.out_x, res.out_y, res.out_z, res.nonzero);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/tb_half_vector_normalizer_top.sv @@
// Testbench top: stimulus, receiver stalls and the verdict for the half vector normalizer.
`timescale 1ns / 100ps
module tb_half_vector_normalizer_top;
    import hvn_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    vec_in_t  vec;
    logic     empty;
    logic     pop;
    vec_out_t res;
    int       mismatches;
    int       pending;
    int       results_seen;
    int       sent;
    bit       hold_done;

    half_vector_normalizer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .vec   (vec),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    hvn_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .vec          (vec),
        .empty        (empty),
        .pop          (pop),
        .res          (res),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [15:0] unit_comp();
        return 16'($signed($urandom_range(32768)) - 32'sd16384);
    endfunction

    function automatic vec_in_t make_vec(int kind);
        vec_in_t v;
        v = {$urandom, $urandom, $urandom};
        case (kind)
            0:  // arbitrary 16-bit patterns
                ;
            1:  // plain normalize
            begin
                v.light_x = unit_comp(); v.light_y = unit_comp(); v.light_z = unit_comp();
                v.view_x = '0; v.view_y = '0; v.view_z = '0;
            end
            2:  // opposite directions cancel
            begin
                v.light_x = unit_comp(); v.light_y = unit_comp(); v.light_z = unit_comp();
                v.view_x = -v.light_x; v.view_y = -v.light_y; v.view_z = -v.light_z;
            end
            3:  // tiny sums
            begin
                v.light_x = 16'($signed($urandom_range(6)) - 3);
                v.light_y = 16'($signed($urandom_range(6)) - 3);
                v.light_z = 16'($signed($urandom_range(6)) - 3);
                v.view_x = '0; v.view_y = '0; v.view_z = '0;
            end
            default:
            begin
                v.light_x = unit_comp(); v.light_y = unit_comp(); v.light_z = unit_comp();
                v.view_x = unit_comp(); v.view_y = unit_comp(); v.view_z = unit_comp();
            end
        endcase
        return v;
    endfunction

    // Holds push high until the transfer happens; push stays high for back-to-back items.
    task automatic send(vec_in_t v);
        push <= 1'b1;
        vec  <= v;
        do @(posedge clk); while (full);
        sent++;
    endtask

    task automatic idle(int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_dir(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                            logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
        send({lx, ly, lz, vx, vy, vz});
    endtask

    // Receiver: rotates among free-running, random and mostly stalled modes,
    // with one long hold-off so the queue backs up into full.
    initial
    begin
        int cyc;
        int mode;
        pop = 1'b0;
        cyc = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                mode = $urandom_range(2);
            if (cyc >= 200 && cyc < 500)
            begin
                pop <= 1'b0;
                if (cyc == 499)
                    hold_done = 1'b1;
            end
            else if (mode == 0)
                pop <= 1'b1;
            else if (mode == 1)
                pop <= $urandom_range(1);
            else
                pop <= ($urandom_range(5) == 0);
        end
    end

    initial
    begin
        #400000;
        $display("[half_vector_normalizer_top] ERROR");
        $finish;
    end

    initial
    begin
        int gap;
        int burst;
        int wait_cyc;
        push  = 1'b0;
        vec   = '0;
        sent  = 0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases
        send_dir(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);           // zero sum
        send_dir(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // exactly unit
        send_dir(16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'd0);
        send_dir(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd8192);     // unit from two halves
        send_dir(16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384);
        send_dir(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
                 -16'sd16384);
        send_dir(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_dir(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_dir(16'h7fff, 16'h8000, 16'd0, 16'h8000, 16'h7fff, 16'd0);
        send_dir(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_dir(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_dir(16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
        send_dir(-16'sd1, 16'd2, -16'sd2, 16'd0, 16'd0, 16'd0);
        send_dir(16'd5000, -16'sd7000, 16'd300, -16'sd5000, 16'd7000, -16'sd300); // cancel
        send_dir(16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
        send_dir(16'd11585, 16'd11585, 16'd0, 16'd0, 16'd0, 16'd0);
        send_dir(16'd3, 16'd4, 16'd0, 16'd0, 16'd0, 16'd0);
        send_dir(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        idle(5);

        // random bursts: mostly unit-range directions, some raw, cancelling or tiny-sum vectors
        while (sent < 550 || !hold_done)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
                send(make_vec($urandom_range(9) < 2 ? $urandom_range(3) : 4));
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            idle(gap);
        end
        push <= 1'b0;

        wait_cyc = 0;
        while (pending != 0 && wait_cyc < 20000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (30) @(posedge clk);

        $display("Sent %0d vectors (directed extremes, zero and unit sums, random bursts);",
                 sent);
        $display("checked %0d results under random and long receiver stalls.", results_seen);
        if (mismatches == 0 && pending == 0)
            $display("[half_vector_normalizer_top] OK");
        else
            $display("[half_vector_normalizer_top] ERROR");
        $finish;
    end
endmodule
